FILE: design/mh64_pkg.sv
// Shared constants, types and helper functions for the MurmurHash64A stream block.
package mh64_pkg;

    localparam logic [63:0] MH_SEED    = 64'hDECAFBADDECAFBAD;
    localparam logic [63:0] MH_MUL     = 64'hC6A4A7935BD1E995;
    localparam int          MH_SHIFT   = 47;
    localparam int          MUL_STEPS  = 3;
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEED,
        ST_KEY1,
        ST_KEY2,
        ST_HASH,
        ST_FIN,
        ST_OUT
    } mh64_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mh64_mul_stat_t;

    function automatic logic [63:0] fold_shift(input logic [63:0] x);
        return x ^ (x >> MH_SHIFT);
    endfunction

    // Keeps the low bytes of a word that are below the byte count.
    function automatic logic [63:0] tail_mask(input logic [3:0] count);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < count)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: design/mh64_mul.sv
// Multi-cycle 64-bit multiply by the hash constant, modulo 2^64, on one 32x32 multiplier.
module mh64_mul
    import mh64_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [63:0]    operand,
    output mh64_mul_stat_t stat,
    output logic [63:0]    result
);

    localparam logic [1:0] LAST_STEP = 2'(MUL_STEPS - 1);

    logic [63:0] a_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] a_sel;
    logic [31:0] m_sel;
    logic [63:0] prod;

    // Low half of the product: lo*lo, then both cross terms land in the upper word.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                a_sel = a_reg[31:0];
                m_sel = MH_MUL[31:0];
            end
            2'd1:
            begin
                a_sel = a_reg[31:0];
                m_sel = MH_MUL[63:32];
            end
            default:
            begin
                a_sel = a_reg[63:32];
                m_sel = MH_MUL[31:0];
            end
        endcase
    end

    assign prod = {32'b0, a_sel} * {32'b0, m_sel};

    always_comb
    begin
        if (step_reg == 2'd0)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = busy_reg && (step_reg == LAST_STEP);
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= operand;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

FILE: design/murmurhash64a_stream.sv
// Top level of the streaming MurmurHash64A engine: sequencer, hash state and output register.
//
// Input stream (s_axis): one transaction carries up to eight message bytes.
// tuser flags the first word of a message, which seeds the hash from the
// message length; tlast flags the final word, after which the hash is
// finalized and sent as one transaction on m_axis.
// Every 64-bit multiply runs on one shared 32x32 multiplier in three passes.
// A full word takes three multiplies in turn (key, key after the fold, then
// the hash), a short tail one, an empty word none; a word that opens a
// message first runs the seed multiply from the length and is then dispatched
// again. A last word adds the finalization multiply, and its hash is then
// loaded into the output register.
// s_axis_tready is high only while the engine is idle.
// Reset clears the running hash to zero and empties the output register.
// The result waits in the output register while m_axis_tready is low; the
// next message word can already be taken and hashed meanwhile, and only a
// second finished hash waits for the register to drain.
module murmurhash64a_stream
    import mh64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] message_length, [95:32] data_word, [99:96] byte_count, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    // [0] first_item
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] hash_value
    output logic [63:0]  m_axis_tdata
);

    mh64_state_t    state_reg;
    mh64_state_t    state_next;
    logic [63:0]    h_reg;
    logic [63:0]    h_next;
    logic [63:0]    word_reg;
    logic [31:0]    len_reg;
    logic [3:0]     cnt_reg;
    logic [3:0]     cnt_in;
    logic           first_reg;
    logic           first_next;
    logic           last_reg;
    logic           out_valid_reg;
    logic [63:0]    out_data_reg;
    logic           accept;
    logic           out_free;
    logic           out_load;
    logic           mul_start;
    logic [63:0]    mul_operand;
    logic [63:0]    mul_result;
    mh64_mul_stat_t mul_stat;

    mh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .stat    (mul_stat),
        .result  (mul_result)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cnt_in        = (s_axis_tdata[99:96] > FULL_COUNT) ? FULL_COUNT : s_axis_tdata[99:96];
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (first_reg)
                begin
                    state_next = ST_SEED;
                end
                else if (cnt_reg == FULL_COUNT)
                begin
                    state_next = ST_KEY1;
                end
                else if (cnt_reg != 4'd0)
                begin
                    state_next = ST_HASH;
                end
                else if (last_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEED:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_KEY1:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_KEY2;
                end
            end
            ST_KEY2:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mul_stat.done)
                begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Multiplier issue and hash updates for each step.
    always_comb
    begin
        mul_start   = 1'b0;
        mul_operand = word_reg;
        h_next      = h_reg;
        first_next  = first_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (first_reg)
                begin
                    mul_start   = 1'b1;
                    mul_operand = {32'b0, len_reg};
                end
                else if (cnt_reg == FULL_COUNT)
                begin
                    mul_start   = 1'b1;
                    mul_operand = word_reg;
                end
                else if (cnt_reg != 4'd0)
                begin
                    mul_start   = 1'b1;
                    mul_operand = h_reg ^ (word_reg & tail_mask(cnt_reg));
                end
                else if (last_reg)
                begin
                    mul_start   = 1'b1;
                    mul_operand = fold_shift(h_reg);
                end
            end
            ST_SEED:
            begin
                if (mul_stat.done)
                begin
                    h_next     = MH_SEED ^ mul_result;
                    first_next = 1'b0;
                end
            end
            ST_KEY1:
            begin
                if (mul_stat.done)
                begin
                    mul_start   = 1'b1;
                    mul_operand = fold_shift(mul_result);
                end
            end
            ST_KEY2:
            begin
                if (mul_stat.done)
                begin
                    mul_start   = 1'b1;
                    mul_operand = h_reg ^ mul_result;
                end
            end
            ST_HASH:
            begin
                if (mul_stat.done)
                begin
                    h_next = mul_result;
                    if (last_reg)
                    begin
                        mul_start   = 1'b1;
                        mul_operand = fold_shift(mul_result);
                    end
                end
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= '0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            if (accept)
            begin
                first_reg <= s_axis_tuser;
                last_reg  <= s_axis_tlast;
            end
            else
            begin
                first_reg <= first_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg  <= s_axis_tdata[31:0];
            word_reg <= s_axis_tdata[95:32];
            cnt_reg  <= cnt_in;
        end
        if (out_load)
        begin
            out_data_reg <= fold_shift(mul_result);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The shared multiplier is never left running when a new word may come in.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mul_stat.busy)
        else $error("multiplier busy while the engine is idle");

    // A multiply result only arrives while the sequencer is waiting for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == ST_SEED || state_reg == ST_KEY1 ||
                           state_reg == ST_KEY2 || state_reg == ST_HASH ||
                           state_reg == ST_FIN))
        else $error("multiplier result arrived in a state that does not use it");

    // A new output transaction is produced only by the output step of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("output became valid outside the output step");

endmodule

FILE: test/tb.sv
// Self-checking stream testbench for the MurmurHash64A engine with a built-in hash predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mh64_pkg::*;

    // Predicts each finished hash from the accepted words and checks the results in order.
    class hash_scoreboard;
        logic [63:0] hash_state;
        logic [63:0] pending_hashes[$];
        int unsigned mismatches;
        int unsigned hashes_checked;

        function new();
            hash_state = '0;
            mismatches = 0;
            hashes_checked = 0;
        endfunction

        function void note_word(bit first, logic [31:0] len, logic [63:0] word,
                                logic [3:0] count, bit last);
            logic [63:0] h;
            logic [63:0] k;
            logic [63:0] keep;
            int unsigned n;
            h = hash_state;
            n = (count > 4'd8) ? 8 : int'(count);
            if (first)
            begin
                h = MH_SEED ^ (64'(len) * MH_MUL);
            end
            if (n == 8)
            begin
                k = word * MH_MUL;
                k = k ^ (k >> MH_SHIFT);
                k = k * MH_MUL;
                h = (h ^ k) * MH_MUL;
            end
            else if (n > 0)
            begin
                keep = (64'd1 << (8 * n)) - 64'd1;
                h = (h ^ (word & keep)) * MH_MUL;
            end
            hash_state = h;
            if (last)
            begin
                // The stored state keeps the value from before the final avalanche.
                h = h ^ (h >> MH_SHIFT);
                h = h * MH_MUL;
                h = h ^ (h >> MH_SHIFT);
                pending_hashes = {pending_hashes, h};
            end
        endfunction

        function void check_hash(logic [63:0] actual);
            logic [63:0] wanted;
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, actual %h", $time, actual);
                mismatches++;
                return;
            end
            wanted = pending_hashes.pop_front();
            hashes_checked++;
            if (actual !== wanted)
            begin
                $display("%0t: hash mismatch, expected %h, actual %h", $time, wanted, actual);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_hashes.size();
        endfunction

        function void flag_leftovers();
            while (pending_hashes.size() != 0)
            begin
                $display("%0t: missing hash, expected %h, actual none", $time,
                         pending_hashes.pop_front());
                mismatches++;
            end
        endfunction
    endclass

    localparam int HOLD_OFF_CYCLES = 400;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;

    hash_scoreboard sb = new();
    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    int unsigned messages_sent = 0;
    bit drained = 1'b0;

    murmurhash64a_stream DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Offers one word and returns at the edge where the transaction completes.
    task automatic send_word(bit first, logic [31:0] len, logic [63:0] word,
                             logic [3:0] count, bit last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, count, word, len};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(first, len, word, count, last);
        words_sent++;
        if (last)
        begin
            messages_sent++;
        end
    endtask

    // Sends a well-formed message of nbytes random bytes, optionally closed by an empty word.
    task automatic send_message(int unsigned nbytes, logic [31:0] len_field, bit empty_close);
        int unsigned left;
        int unsigned n;
        bit first;
        left = nbytes;
        first = 1'b1;
        if (nbytes == 0)
        begin
            send_word(1'b1, len_field, rand_word(), 4'd0, 1'b1);
            return;
        end
        while (left > 0)
        begin
            n = (left >= 8) ? 8 : left;
            left -= n;
            send_word(first, len_field, rand_word(), 4'(n), (left == 0) && !empty_close);
            first = 1'b0;
        end
        if (empty_close)
        begin
            send_word(1'b0, len_field, rand_word(), 4'd0, 1'b1);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_hash(m_axis_tdata);
        end
    end

    // Receiver: random stall patterns, plus one long hold-off once traffic is under way.
    initial
    begin
        int unsigned mode;
        int unsigned stretch;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && words_sent >= 250)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(4, 40);
            repeat (stretch)
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #3ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        int unsigned nbytes;
        int unsigned waited;
        logic [31:0] len_field;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A word without a first flag right after reset continues from a zero hash.
        send_word(1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        // After a last word the state carries on into the next one.
        send_word(1'b0, 32'h0, rand_word(), 4'd3, 1'b1);
        // Empty message: only the length seed and the final avalanche.
        send_word(1'b1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
        // Largest length field, then a byte count above eight on the last word.
        send_word(1'b1, 32'hFFFF_FFFF, 64'h0, 4'd8, 1'b0);
        send_word(1'b0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        // Every short tail size, with random bytes above the count.
        for (int c = 1; c < 8; c++)
        begin
            send_word(1'b1, 32'(c), rand_word(), 4'(c), 1'b1);
        end
        // Empty and short words in the middle of a message, and a count of nine.
        send_word(1'b1, 32'd20, rand_word(), 4'd0, 1'b0);
        send_word(1'b0, 32'h0, rand_word(), 4'd5, 1'b0);
        send_word(1'b0, 32'h0, rand_word(), 4'd9, 1'b0);
        send_word(1'b0, 32'h0, rand_word(), 4'd4, 1'b1);
        // A second first flag inside a message reseeds the hash.
        send_word(1'b1, 32'd16, rand_word(), 4'd8, 1'b0);
        send_word(1'b1, 32'd16, rand_word(), 4'd8, 1'b0);
        send_word(1'b0, 32'h0, rand_word(), 4'd0, 1'b1);
        send_word(1'b1, 32'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 1'b1);
        send_message(16, 32'd16, 1'b0);

        while (words_sent < 770)
        begin
            if (!drained && words_sent >= 500)
            begin
                drained = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                send_word(1'($urandom_range(0, 1)), $urandom(), rand_word(),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 16)
                begin
                    nbytes = $urandom_range(0, 24);
                end
                else if (pick < 19)
                begin
                    nbytes = $urandom_range(25, 64);
                end
                else
                begin
                    nbytes = $urandom_range(65, 160);
                end
                len_field = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(nbytes);
                send_message(nbytes, len_field,
                             (nbytes % 8 == 0) && ($urandom_range(0, 3) == 0));
            end
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        sb.flag_leftovers();

        $display("Run covered %0d input transactions in %0d messages and checked %0d hashes,",
                 words_sent, messages_sent, sb.hashes_checked);
        $display("with a %0d-cycle receiver hold-off and one full drain of pending results.",
                 HOLD_OFF_CYCLES);
        if (sb.mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
